@@ rtl/core/swp_pkg.sv @@
// package: types and constants for the sliding-window percentile core
`timescale 1ns / 1ps
package swp_pkg;
  localparam int WINDOW_MAX   = 128;
  localparam int LATENCY_BITS = 32;
  localparam int CNT_BITS     = $clog2(WINDOW_MAX + 1);
  localparam int NUM_FIELDS   = 4;

  typedef logic [LATENCY_BITS-1:0] lat_t;
  typedef logic [CNT_BITS-1:0]     cnt_t;

  typedef struct packed {
    lat_t pre_latency;
    lat_t infer_latency;
    lat_t post_latency;
    lat_t total_latency;
  } in_item_t;

  typedef struct packed {
    lat_t pre_median;
    lat_t pre_p99;
    lat_t infer_median;
    lat_t infer_p99;
    lat_t post_median;
    lat_t post_p99;
    lat_t total_median;
    lat_t total_p99;
    logic [7:0] sample_count;
  } out_item_t;

  // one sample of four fields held in one cell
  typedef struct packed {
    lat_t [NUM_FIELDS-1:0] lat;
  } smp_t;

  // control broadcast to every cell
  typedef struct packed {
    logic load;     // capture new sample, shift age chain
    logic scan;     // shift rank chain one step
    smp_t  data;    // new sample
    cnt_t  count;   // entries valid after insert
  } cell_ctl_t;

  typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_OUT} state_t;
endpackage

@@ rtl/core/swp_cell.sv @@
// one cell: holds one sample in age order and counts smaller and equal held values
`timescale 1ns / 1ps
module swp_cell (
  input  logic              clk,
  input  swp_pkg::cell_ctl_t ctl,
  input  logic [swp_pkg::CNT_BITS-1:0] idx,
  input  swp_pkg::smp_t     prev_smp,
  input  swp_pkg::smp_t     scan_in,
  output swp_pkg::smp_t     smp,
  output swp_pkg::smp_t     scan_out,
  output logic [swp_pkg::NUM_FIELDS-1:0][swp_pkg::CNT_BITS-1:0] less_cnt,
  output logic [swp_pkg::NUM_FIELDS-1:0][swp_pkg::CNT_BITS-1:0] eq_before
);
  swp_pkg::smp_t smp_r, scan_r;
  logic [swp_pkg::NUM_FIELDS-1:0][swp_pkg::CNT_BITS-1:0] less_r, eqb_r;
  logic active;

  assign active = idx < ctl.count;

  // age chain: cell 0 takes the new sample, others take their neighbor
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      smp_r  <= (idx == '0) ? ctl.data : prev_smp;
      scan_r <= (idx == '0) ? ctl.data : prev_smp;
      less_r <= '0;
      eqb_r  <= '0;
    end else if (ctl.scan) begin
      // compare own value to the value passing by on the rotating chain
      scan_r <= scan_in;
      for (int f = 0; f < swp_pkg::NUM_FIELDS; f++) begin
        if (active && scan_in.lat[f] < smp_r.lat[f])
          less_r[f] <= less_r[f] + 1'b1;
        if (active && scan_in.lat[f] == smp_r.lat[f])
          eqb_r[f] <= eqb_r[f] + 1'b1;
      end
    end
  end

  assign smp       = smp_r;
  assign scan_out  = scan_r;
  assign less_cnt  = less_r;
  assign eq_before = eqb_r;
endmodule

@@ rtl/core/sliding_window_percentiles_core.sv @@
// top level: chain of sample cells with rank scan and percentile select
// a result is registered after the rotating rank scan over all held samples, new one included
// one item at a time: a new sample is taken only in idle, once the last result is handed off
// an untaken result stalls the hand-off
// reset: window length 128, store empty, no result pending
// a window_length write empties the store at once
`timescale 1ns / 1ps
module sliding_window_percentiles_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  swp_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output swp_pkg::out_item_t out_data,
  input  logic               cfg_we,
  input  logic [7:0]         cfg_data
);
  localparam int W = swp_pkg::WINDOW_MAX;
  localparam int CB = swp_pkg::CNT_BITS;
  localparam int NF = swp_pkg::NUM_FIELDS;
  localparam int LB = swp_pkg::LATENCY_BITS;
  localparam int IB = $clog2(W);

  swp_pkg::state_t state_r, state_nxt;
  logic [CB-1:0] len_r, held_r, step_r, step_nxt;
  logic [CB-1:0] count;
  swp_pkg::cell_ctl_t ctl;
  swp_pkg::smp_t smp [W];
  swp_pkg::smp_t scn [W];
  logic [NF-1:0][CB-1:0] lc [W];
  logic [NF-1:0][CB-1:0] eb [W];
  logic [CB-1:0] r50, r99, hund;
  logic [IB-1:0] last_idx;
  swp_pkg::out_item_t out_r, sel;
  logic out_valid_r;
  logic accept;
  logic out_load;

  assign accept = in_valid && in_ready;
  assign count  = (held_r < len_r) ? held_r + 1'b1 : len_r;

  // ranks: ceil(n/2) and n - floor(n/100), both within 1..n for n>=1
  assign r50 = (held_r + 1'b1) >> 1;
  always_comb begin
    hund = '0;
    for (int k = 100; k <= W; k += 100) begin
      if (held_r >= CB'(k)) hund = hund + 1'b1;
    end
    r99 = held_r - hund;
  end

  assign ctl.load  = accept;
  assign ctl.scan  = (state_r == swp_pkg::ST_SCAN);
  assign ctl.data  = swp_pkg::smp_t'({in_data.pre_latency, in_data.infer_latency,
                                      in_data.post_latency, in_data.total_latency});
  assign ctl.count = held_r;

  assign last_idx = IB'(held_r - 1'b1);

  // cell row; scan chain rotates within the held part
  for (genvar i = 0; i < W; i++) begin : g_cell
    swp_pkg::smp_t pin, sin;
    if (i == 0) begin : g_first
      assign pin = '0;
      assign sin = scn[last_idx];
    end else begin : g_rest
      assign pin = smp[i-1];
      assign sin = scn[i-1];
    end
    swp_cell u_cell (
      .clk(clk), .ctl(ctl), .idx(CB'(i)), .prev_smp(pin), .scan_in(sin),
      .smp(smp[i]), .scan_out(scn[i]), .less_cnt(lc[i]), .eq_before(eb[i])
    );
  end

  // state register and counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= swp_pkg::ST_IDLE;
      len_r       <= CB'(W);
      held_r      <= '0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      if (cfg_we) begin
        len_r  <= (cfg_data == 8'd0) ? CB'(1) :
                  ({1'b0, cfg_data} > (CB+1)'(W)) ? CB'(W) : CB'(cfg_data);
        held_r <= '0;
      end else if (accept) begin
        held_r <= count;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    in_ready  = 1'b0;
    out_load  = 1'b0;
    case (state_r)
      swp_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_nxt = swp_pkg::ST_SCAN;
          step_nxt  = '0;
        end
      end
      swp_pkg::ST_SCAN: begin
        step_nxt = step_r + 1'b1;
        if (step_r + 1'b1 == held_r) state_nxt = swp_pkg::ST_OUT;
      end
      swp_pkg::ST_OUT: begin
        // hand off once the output register is free
        if (!out_valid_r || out_ready) begin
          out_load  = 1'b1;
          state_nxt = swp_pkg::ST_IDLE;
        end
      end
      default: state_nxt = swp_pkg::ST_IDLE;
    endcase
  end

  // rank select: cell whose sorted position range covers the rank
  always_comb begin
    sel = '0;
    for (int g = 0; g < NF; g++) begin
      for (int i = 0; i < W; i++) begin
        if (CB'(i) < held_r) begin
          if (lc[i][g] < r50 && lc[i][g] + eb[i][g] >= r50)
            sel[(2*g+1)*LB+8 +: LB] = sel[(2*g+1)*LB+8 +: LB] | smp[i].lat[g];
          if (lc[i][g] < r99 && lc[i][g] + eb[i][g] >= r99)
            sel[(2*g)*LB+8 +: LB] = sel[(2*g)*LB+8 +: LB] | smp[i].lat[g];
        end
      end
    end
    sel.sample_count = 8'(held_r);
  end

  // output register
  always_ff @(posedge clk) begin
    if (out_load) out_r <= sel;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // checks
  a_held: assert property (@(posedge clk) disable iff (!rst_n) held_r <= len_r)
    else $error("held count above window length");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result dropped or changed while waiting");
  a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.sample_count != 8'd0) else $error("empty result");
endmodule

@@ test/tb_top.sv @@
// testbench for the sliding-window percentile core: random and directed samples vs predictor
`timescale 1ns / 1ps
module tb_top;
  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  swp_pkg::in_item_t  in_data;
  logic               out_valid;
  logic               out_ready;
  swp_pkg::out_item_t out_data;
  logic               cfg_we;
  logic [7:0]         cfg_data;

  sliding_window_percentiles_core u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  // predictor state
  swp_pkg::lat_t win_pre [swp_pkg::WINDOW_MAX];
  swp_pkg::lat_t win_inf [swp_pkg::WINDOW_MAX];
  swp_pkg::lat_t win_post [swp_pkg::WINDOW_MAX];
  swp_pkg::lat_t win_tot [swp_pkg::WINDOW_MAX];
  int unsigned oldest_pos;
  int unsigned held;
  int unsigned win_len_reg;

  swp_pkg::in_item_t  sample_q[$];
  swp_pkg::out_item_t pct_expect_q[$];
  int        send_idle_pct;
  int        recv_idle_pct;
  int        errors = 0;
  longint    cycle_cnt = 0;
  bit        hold_send;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // pick rank value of one field over the held samples
  function automatic void rank_pick(input swp_pkg::lat_t win[swp_pkg::WINDOW_MAX],
                                    input int unsigned n, input int unsigned len,
                                    output swp_pkg::lat_t p50, output swp_pkg::lat_t p99);
    swp_pkg::lat_t srt[$];
    int unsigned r50;
    int unsigned r99;
    for (int i = 0; i < n; i++) srt.insert(srt.size(), win[(oldest_pos + i) % len]);
    srt.sort();
    r50 = (50 * n + 99) / 100;
    r99 = (99 * n + 99) / 100;
    if (r50 < 1) r50 = 1;
    if (r50 > n) r50 = n;
    if (r99 < 1) r99 = 1;
    if (r99 > n) r99 = n;
    p50 = srt[r50 - 1];
    p99 = srt[r99 - 1];
  endfunction

  // insert one sample into the window and predict percentiles
  function automatic swp_pkg::out_item_t percentile_predict(input swp_pkg::in_item_t s);
    swp_pkg::out_item_t r;
    int unsigned len;
    int unsigned slot;
    len = win_len_reg;
    if (len == 0) len = 1;
    if (len > swp_pkg::WINDOW_MAX) len = swp_pkg::WINDOW_MAX;
    if (held > len) held = len;
    oldest_pos = oldest_pos % len;
    if (held < len) begin
      slot = (oldest_pos + held) % len;
      held++;
    end else begin
      slot = oldest_pos;
      oldest_pos = (oldest_pos + 1) % len;
    end
    win_pre[slot]  = s.pre_latency;
    win_inf[slot]  = s.infer_latency;
    win_post[slot] = s.post_latency;
    win_tot[slot]  = s.total_latency;
    rank_pick(win_pre, held, len, r.pre_median, r.pre_p99);
    rank_pick(win_inf, held, len, r.infer_median, r.infer_p99);
    rank_pick(win_post, held, len, r.post_median, r.post_p99);
    rank_pick(win_tot, held, len, r.total_median, r.total_p99);
    r.sample_count = held[7:0];
    return r;
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data  <= '0;
    end else if (in_valid && !in_ready) begin
      // hold item
    end else begin
      if (in_valid && in_ready)
        pct_expect_q.insert(pct_expect_q.size(), percentile_predict(in_data));
      if (sample_q.size() > 0 && !hold_send && $urandom_range(99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        in_data  <= sample_q[0];
        sample_q.delete(0);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (pct_expect_q.size() == 0) begin
          $error("result with no expectation: %h", out_data);
          errors++;
        end else begin
          swp_pkg::out_item_t e;
          e = pct_expect_q[0];
          pct_expect_q.delete(0);
          if (e.pre_median !== out_data.pre_median) begin
            $error("pre_median exp %h got %h", e.pre_median, out_data.pre_median); errors++;
          end
          if (e.pre_p99 !== out_data.pre_p99) begin
            $error("pre_p99 exp %h got %h", e.pre_p99, out_data.pre_p99); errors++;
          end
          if (e.infer_median !== out_data.infer_median) begin
            $error("infer_median exp %h got %h", e.infer_median, out_data.infer_median);
            errors++;
          end
          if (e.infer_p99 !== out_data.infer_p99) begin
            $error("infer_p99 exp %h got %h", e.infer_p99, out_data.infer_p99); errors++;
          end
          if (e.post_median !== out_data.post_median) begin
            $error("post_median exp %h got %h", e.post_median, out_data.post_median);
            errors++;
          end
          if (e.post_p99 !== out_data.post_p99) begin
            $error("post_p99 exp %h got %h", e.post_p99, out_data.post_p99); errors++;
          end
          if (e.total_median !== out_data.total_median) begin
            $error("total_median exp %h got %h", e.total_median, out_data.total_median);
            errors++;
          end
          if (e.total_p99 !== out_data.total_p99) begin
            $error("total_p99 exp %h got %h", e.total_p99, out_data.total_p99); errors++;
          end
          if (e.sample_count !== out_data.sample_count) begin
            $error("sample_count exp %0d got %0d", e.sample_count, out_data.sample_count);
            errors++;
          end
        end
      end
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // timeout
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > 3000000) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic swp_pkg::lat_t rand_lat();
    case ($urandom_range(5))
      0: rand_lat = '0;
      1: rand_lat = '1;
      2: rand_lat = swp_pkg::lat_t'($urandom_range(7));
      3: rand_lat = swp_pkg::lat_t'(32'hFFFF_FFF8 + $urandom_range(7));
      default: rand_lat = $urandom;
    endcase
  endfunction

  function automatic swp_pkg::in_item_t rand_sample();
    swp_pkg::in_item_t s;
    s.pre_latency   = rand_lat();
    s.infer_latency = rand_lat();
    s.post_latency  = rand_lat();
    s.total_latency = rand_lat();
    return s;
  endfunction

  // wait until every queued item is sent and answered, then settle
  task automatic drain();
    while (sample_q.size() > 0 || in_valid || pct_expect_q.size() > 0) @(posedge clk);
    repeat (140) @(posedge clk);
  endtask

  // write window length while idle, predictor follows
  task automatic write_len(input logic [7:0] v);
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    win_len_reg = v;
    held = 0;
    oldest_pos = 0;
  endtask

  initial begin
    logic [7:0] lens[6];
    swp_pkg::in_item_t s;
    lens = '{8'd1, 8'd2, 8'd0, 8'd255, 8'd128, 8'd7};
    hold_send = 1'b0;
    send_idle_pct = 31;
    recv_idle_pct = 67;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_data = '0;
    win_len_reg = 128;
    held = 0;
    oldest_pos = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extremes and ties at reset length
    s = '0;
    sample_q.insert(sample_q.size(), s);
    s = '1;
    sample_q.insert(sample_q.size(), s);
    for (int i = 0; i < 10; i++) begin
      s.pre_latency   = swp_pkg::lat_t'(i);
      s.infer_latency = swp_pkg::lat_t'(32'hFFFF_FFFF - i);
      s.post_latency  = swp_pkg::lat_t'(5);
      s.total_latency = swp_pkg::lat_t'(32'h8000_0000 ^ i);
      sample_q.insert(sample_q.size(), s);
    end
    drain();
    // directed: small windows and zero length
    write_len(8'd1);
    for (int i = 0; i < 4; i++) sample_q.insert(sample_q.size(), rand_sample());
    drain();
    write_len(8'd0);
    for (int i = 0; i < 3; i++) sample_q.insert(sample_q.size(), rand_sample());
    drain();
    write_len(8'd2);
    for (int i = 0; i < 5; i++) sample_q.insert(sample_q.size(), rand_sample());
    drain();

    // random phases over several lengths and idling patterns
    for (int ph = 0; ph < 6; ph++) begin
      int unsigned n;
      if (ph == 2) begin
        send_idle_pct = 67; recv_idle_pct = 31;
      end
      if (ph == 4) begin
        send_idle_pct = 0; recv_idle_pct = 0;
      end
      write_len(ph == 5 ? 8'($urandom_range(3, 100)) : lens[ph]);
      n = (lens[ph] >= 128 || ph == 5) ? 300 : 330;
      for (int i = 0; i < n; i++) sample_q.insert(sample_q.size(), rand_sample());
      if (ph == 1) begin
        // pause sender until all results are back
        while (sample_q.size() > 150) @(posedge clk);
        hold_send = 1'b1;
        while (in_valid || pct_expect_q.size() > 0) @(posedge clk);
        hold_send = 1'b0;
      end
      drain();
    end

    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule

@@ files.f @@
rtl/core/swp_pkg.sv
rtl/core/swp_cell.sv
rtl/core/sliding_window_percentiles_core.sv
test/tb_top.sv
